@@ sv/arp_pkg.sv @@
// Package: types, constants and codes shared by the ARP cache resolver.
package arp_pkg;

    localparam int unsigned DefEntries = 16;

    localparam logic [31:0] DefEntryLife   = 32'd120000;
    localparam logic [31:0] DefPendingLife = 32'd3000;
    localparam logic [31:0] DefRetry       = 32'd1000;

    localparam logic [31:0] IpAllOnes  = 32'hFFFF_FFFF;
    localparam logic [47:0] MacBcast   = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_FREE    = 2'd0,
        KIND_PENDING = 2'd1,
        KIND_VALID   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_REJECTED = 3'd0,
        ST_OWN      = 3'd1,
        ST_BCAST    = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4,
        ST_LEARNED  = 3'd5,
        ST_REFUSED  = 3'd6
    } t_status;

    localparam logic [2:0] REG_OWN_IP       = 3'd0;
    localparam logic [2:0] REG_SUBNET_MASK  = 3'd1;
    localparam logic [2:0] REG_OWN_MAC      = 3'd2;
    localparam logic [2:0] REG_LINK_UP      = 3'd3;
    localparam logic [2:0] REG_ENTRY_LIFE   = 3'd4;
    localparam logic [2:0] REG_PENDING_LIFE = 3'd5;
    localparam logic [2:0] REG_RETRY        = 3'd6;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_LEARN  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] query_ip;
        logic [47:0] src_mac;
        logic        aimed_at_us;
        logic [31:0] time_ms;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] resolved_mac;
        logic        send_request;
    } t_resp;

    // one cache slot as stored in memory
    typedef struct packed {
        logic [31:0] addr;
        logic [47:0] hw;
        logic [31:0] learned;
        logic [31:0] asked;
    } t_slot;

endpackage

@@ sv/arp_cache_resolver.sv @@
// Top level: ARP cache; one sweep over the slot memories expires, finds and picks slots.
//
// Usage:
//   Pulse i_start with i_req while o_busy is low; the transaction is taken on that edge.
//   The block then sweeps the slot memories once, one slot a cycle:
//     pass 1 reads each slot, expires it and writes its kind back, while tracking
//            the matching slot, the first free slot, the oldest pending slot
//            and the least recently learned slot;
//     then S_LAST checks the last slot, S_DEC decides, S_OUT writes the chosen slot.
//   The result appears on o_resp for exactly one cycle with o_valid high.
//   The strobe follows the sweep and the S_LAST and S_DEC states; the next
//   transaction can be accepted the cycle after o_valid, so the block takes
//   no new transaction while one is in flight. The sweep of the memory port
//   (one read per cycle) bounds the transaction rate.
//   The receiver cannot stall: the strobe lasts one cycle.
//   Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_data) take effect at once
//   and are to be issued only while idle.
//   Reset (i_rst_n low, synchronous) starts a clearing pass that frees every
//   slot in the kind memory; o_busy stays high until that pass has freed the
//   last slot. The payload memory is not cleared, a free slot never lends
//   its contents to a result.
module arp_cache_resolver #(
    parameter int unsigned CACHE_ENTRIES = arp_pkg::DefEntries
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  arp_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_valid,
    output arp_pkg::t_resp o_resp,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [47:0]    i_cfg_data
);
    import arp_pkg::*;

    localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0] LastIdx = CW'(CACHE_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_LAST  = 6'b000100,
        S_DEC   = 6'b001000,
        S_OUT   = 6'b010000,
        S_CLR   = 6'b100000
    } t_state;

    // configuration
    logic [31:0] r_own_ip, r_mask, r_elife, r_plife, r_retry;
    logic [47:0] r_own_mac;
    logic        r_link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_mask    <= '0;
            r_own_mac <= '0;
            r_link    <= 1'b0;
            r_elife   <= DefEntryLife;
            r_plife   <= DefPendingLife;
            r_retry   <= DefRetry;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OWN_IP:       r_own_ip  <= i_cfg_data[31:0];
                REG_SUBNET_MASK:  r_mask    <= i_cfg_data[31:0];
                REG_OWN_MAC:      r_own_mac <= i_cfg_data;
                REG_LINK_UP:      r_link    <= i_cfg_data[0];
                REG_ENTRY_LIFE:   r_elife   <= i_cfg_data[31:0];
                REG_PENDING_LIFE: r_plife   <= i_cfg_data[31:0];
                REG_RETRY:        r_retry   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // slot payload memory and slot kind memory
    t_slot   mem [CACHE_ENTRIES];
    t_slot   r_rd;
    t_kind   kmem [CACHE_ENTRIES];
    t_kind   r_rk;

    t_state  r_state;
    t_req    r_req;
    logic [CW-1:0] r_ptr;      // address being read
    logic [IW-1:0] r_cidx;     // index of slot now in r_rd
    logic          r_cval;     // r_rd holds a slot to check

    // sweep trackers
    logic          r_fnd, r_fnd_valid;
    logic [IW-1:0] r_fnd_idx;
    logic [47:0]   r_fnd_hw;
    logic [31:0]   r_fnd_asked;
    logic          r_free;
    logic [IW-1:0] r_free_idx;
    logic          r_pend;
    logic [IW-1:0] r_pend_idx;
    logic [31:0]   r_pend_age;
    logic          r_any;
    logic [IW-1:0] r_old_idx;
    logic [31:0]   r_old_age;

    // decision
    logic          r_wr;
    logic [IW-1:0] r_widx;
    t_slot         r_wslot;
    t_kind         r_wkind;
    t_resp         r_resp;

    // checked slot after expiry
    t_kind  cur_kind;
    logic [31:0] age_l, age_a;
    always_comb begin
        age_l    = r_req.time_ms - r_rd.learned;
        age_a    = r_req.time_ms - r_rd.asked;
        cur_kind = r_rk;
        if (cur_kind == KIND_VALID && age_l >= r_elife) cur_kind = KIND_FREE;
        if (cur_kind == KIND_PENDING && age_a >= r_plife) cur_kind = KIND_FREE;
    end

    // decision logic
    logic         is_learn, guard_ok, bcast;
    logic         n_wr;
    logic [IW-1:0] n_widx;
    t_slot        n_wslot;
    t_kind        n_wkind;
    t_resp        n_resp;
    logic         have;
    logic [IW-1:0] pick;
    logic         ask;
    logic [31:0]  asked_v;
    always_comb begin
        is_learn = (r_req.op == OP_LEARN);
        guard_ok = (r_req.query_ip != '0) && !r_req.src_mac[40] &&
                   (r_req.src_mac != '0) &&
                   !((r_own_ip != '0) && (r_req.query_ip == r_own_ip)) &&
                   (r_req.src_mac != r_own_mac);
        bcast    = (r_req.query_ip == IpAllOnes) ||
                   ((r_mask != '0) && (r_req.query_ip == (r_own_ip | ~r_mask)));
        n_wr     = 1'b0;
        n_widx   = r_fnd_idx;
        n_wslot  = '0;
        n_wkind  = KIND_FREE;
        n_resp   = '0;
        ask      = 1'b0;
        asked_v  = '0;
        have     = 1'b1;
        pick     = r_free_idx;
        if (!r_free) begin
            if (r_pend) pick = r_pend_idx;
            else if (is_learn && !r_req.aimed_at_us) have = 1'b0;
            else pick = r_old_idx;
        end
        if (is_learn) begin
            n_resp.status = ST_REFUSED;
            if (guard_ok) begin
                n_resp.status = ST_LEARNED;
                n_wr          = 1'b1;
                n_wkind       = KIND_VALID;
                n_wslot.addr  = r_req.query_ip;
                n_wslot.hw    = r_req.src_mac;
                n_wslot.learned = r_req.time_ms;
                if (r_fnd) begin
                    n_wslot.asked = r_fnd_asked;
                end else if (have) begin
                    n_widx        = pick;
                    n_wslot.asked = r_req.time_ms;
                end else begin
                    n_wr          = 1'b0;
                    n_resp.status = ST_REFUSED;
                end
            end
        end else if (!r_link || r_req.query_ip == '0) begin
            n_resp.status = ST_REJECTED;
        end else if (r_req.query_ip == r_own_ip) begin
            n_resp.status       = ST_OWN;
            n_resp.resolved_mac = r_own_mac;
        end else if (bcast) begin
            n_resp.status       = ST_BCAST;
            n_resp.resolved_mac = MacBcast;
        end else if (r_fnd && r_fnd_valid) begin
            n_resp.status       = ST_HIT;
            n_resp.resolved_mac = r_fnd_hw;
        end else begin
            n_resp.status = ST_MISS;
            n_wkind       = KIND_PENDING;
            n_wslot.addr  = r_req.query_ip;
            n_wslot.learned = r_req.time_ms;
            // a pending hit keeps its learned time and hw (hw zero)
            if (r_fnd) begin
                asked_v = r_fnd_asked;
                n_wslot.learned = r_fnd_asked; // overwritten below
            end else begin
                asked_v = r_req.time_ms - r_retry;
                n_widx  = pick;
            end
            ask = ((r_req.time_ms - asked_v) >= r_retry);
            n_wslot.asked = ask ? r_req.time_ms : asked_v;
            n_wr = 1'b1;
            if (r_fnd) n_wr = ask;
            n_resp.send_request = ask && (r_own_ip != '0);
        end
    end

    // pending hit: keep stored learned time; record it during sweep
    logic [31:0] r_fnd_learned;
    t_slot wslot_fix;
    always_comb begin
        wslot_fix = n_wslot;
        if (!is_learn && r_fnd) wslot_fix.learned = r_fnd_learned;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ptr   <= '0;
            r_cval  <= 1'b0;
            r_wr    <= 1'b0;
        end else begin
            r_wr <= 1'b0;
            case (r_state)
                S_CLR: begin
                    if (r_ptr == LastIdx) begin
                        r_ptr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                end
                S_IDLE: begin
                    r_cval <= 1'b0;
                    if (i_start) begin
                        r_req   <= i_req;
                        r_ptr   <= '0;
                        r_fnd   <= 1'b0;
                        r_free  <= 1'b0;
                        r_pend  <= 1'b0;
                        r_any   <= 1'b0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP, S_LAST: begin
                    if (r_state == S_SWEEP) begin
                        r_cidx <= r_ptr[IW-1:0];
                        r_cval <= 1'b1;
                        if (r_ptr == LastIdx) r_state <= S_LAST;
                        else r_ptr <= r_ptr + CW'(1);
                    end else begin
                        r_cval  <= 1'b0;
                        r_state <= S_DEC;
                    end
                    if (r_cval) begin
                        if (cur_kind != KIND_FREE && r_rd.addr == r_req.query_ip &&
                            !r_fnd) begin
                            r_fnd         <= 1'b1;
                            r_fnd_idx     <= r_cidx;
                            r_fnd_valid   <= (cur_kind == KIND_VALID);
                            r_fnd_hw      <= r_rd.hw;
                            r_fnd_asked   <= r_rd.asked;
                            r_fnd_learned <= r_rd.learned;
                        end
                        if (cur_kind == KIND_FREE && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_cidx;
                        end
                        if (cur_kind == KIND_PENDING && (!r_pend || age_a > r_pend_age)) begin
                            r_pend     <= 1'b1;
                            r_pend_idx <= r_cidx;
                            r_pend_age <= age_a;
                        end
                        if (!r_any || age_l > r_old_age) begin
                            r_any     <= 1'b1;
                            r_old_idx <= r_cidx;
                            r_old_age <= age_l;
                        end
                    end
                end
                S_DEC: begin
                    r_wr    <= n_wr;
                    r_widx  <= n_widx;
                    r_wslot <= wslot_fix;
                    r_wkind <= n_wkind;
                    r_resp  <= n_resp;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // memory ports: one read per cycle; kind write-back during the sweep,
    // clearing after reset, slot write in the output cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && r_wr) begin
            mem[r_widx]  <= r_wslot;
            kmem[r_widx] <= r_wkind;
        end else if (r_state == S_CLR) begin
            kmem[r_ptr[IW-1:0]] <= KIND_FREE;
        end else if (r_cval) begin
            kmem[r_cidx] <= cur_kind;
        end
        r_rd <= mem[r_ptr[IW-1:0]];
        r_rk <= kmem[r_ptr[IW-1:0]];
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_resp  = r_resp;

endmodule

@@ sv/arp_checker.sv @@
// Checker: port-level properties of the ARP cache resolver, bound to the top.
module arp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_valid,
    input arp_pkg::t_resp o_resp
);
    import arp_pkg::*;

    // a result only while a transaction is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result while idle");

    // strobe lasts one cycle and frees the block
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !o_busy) else $error("strobe too long");

    // accept makes the block busy
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");

    // a MAC is given only for own, broadcast or hit
    a_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_resp.status != ST_OWN && o_resp.status != ST_BCAST &&
         o_resp.status != ST_HIT) |-> o_resp.resolved_mac == '0)
        else $error("stray mac");

endmodule

bind arp_cache_resolver arp_checker u_arp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_resp  (o_resp)
);
